### rtl/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// btlpm_pkg
// Types and constants shared by the binary trie prefix lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package btlpm_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_DEPTH = NODE_COUNT - 1;
  localparam int CNT_W      = $clog2(NODE_COUNT) + 1;
  localparam int HOP_BITS   = 8;
  localparam int HOP_W      = 8;
  localparam int MAX_LEVELS = 128;
  localparam int V4_LEVELS  = 32;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
  localparam int PATH_DEPTH = MAX_LEVELS + 1;
  localparam int ADDR_W     = 128;
  localparam int V4_W       = 32;
  localparam int PLEN_W     = 8;

  localparam logic [HOP_W-1:0] HOP_MASK = HOP_W'((1 << HOP_BITS) - 1);

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_EXISTS = 3'd2,
    ST_NORULE = 3'd3,
    ST_FULL   = 3'd4,
    ST_LONG   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_POP,
    S_LINK,
    S_CLR,
    S_PSRD,
    S_NDRD,
    S_UNLINK
  } state_e;

endpackage

`default_nettype wire

### rtl/binary_trie_prefix_lookup_unit.sv
// ----------------------------------------------------------------------------
// binary_trie_prefix_lookup_unit
// Binary trie longest-prefix match with insert and delete, one address bit
// per level, nodes in on-chip memory with a free stack.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser: mode; tdata: addr_high, addr_low, prefix, hop
//  m_axis   | out       | tdata: next_hop, status
//  cfg      | in        | ip_version
//
//  Lookup: one node memory read per address bit, starting from the root.
//  Insert: walk as above, then per newly allocated node S_POP, S_LINK and S_CLR.
//  Delete: walk as above, then per pruned node a path stack read, a node read, an unlink.
//  Reset needs no clearing pass; the free stack reads its reset contents
//  below a low-water mark. A new transaction is taken once the result is gone.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_prefix_lookup_unit import btlpm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // addr_high[63:0], addr_low[127:64], prefix_length[135:128], new_next_hop[143:136]
  input  wire logic [143:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_hop[7:0], status[10:8], zero pad[15:11]
  output logic [15:0]       m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_wdata_i
);

  // node memory
  logic [NODE_W-1:0] left_mem  [NODE_COUNT];
  logic [NODE_W-1:0] right_mem [NODE_COUNT];
  logic [HOP_W-1:0]  hop_mem   [NODE_COUNT];
  logic              rule_mem  [NODE_COUNT];
  logic [NODE_W-1:0] free_mem  [FREE_DEPTH];
  logic [NODE_W-1:0] path_mem  [PATH_DEPTH];

  state_e             state_q, state_d;
  logic               ver_q;
  logic [1:0]         mode_q, mode_d;
  logic [PLEN_W-1:0]  plen_q, plen_d;
  logic [HOP_W-1:0]   hop_q, hop_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [NODE_W-1:0]  cur_node_q, cur_node_d;
  logic [HOP_W-1:0]   res_q, res_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, min_q, min_d;
  logic [NODE_W-1:0]  root_l_q, root_l_d, root_r_q, root_r_d;
  logic [NODE_W-1:0]  rd_node_q;
  logic [NODE_W-1:0]  l_rd_q, r_rd_q;
  logic [HOP_W-1:0]   hop_rd_q;
  logic               rule_rd_q;
  logic [NODE_W-1:0]  fs_rd_q, fs_idx_q, fs_idx_d;
  logic               fs_orig_q, fs_orig_d;
  logic [NODE_W-1:0]  ps_rd_q;
  logic [NODE_W-1:0]  new_q, new_d;
  logic               out_valid_q, out_valid_d;
  logic [HOP_W-1:0]   out_hop_q, out_hop_d;
  status_e            out_st_q, out_st_d;

  // memory ports
  logic               nd_re;
  logic [NODE_W-1:0]  nd_ra;
  logic [NODE_W-1:0]  nd_wa;
  logic               we_l, we_r, we_h, we_rule;
  logic [NODE_W-1:0]  wd_l, wd_r;
  logic [HOP_W-1:0]   wd_h;
  logic               wd_rule;
  logic               fs_re, fs_we;
  logic [NODE_W-1:0]  fs_ra, fs_wa, fs_wd;
  logic               ps_re, ps_we;
  logic [LVL_W-1:0]   ps_ra, ps_wa;

  // view of the node last read; the root lives in registers
  logic               rd_root;
  logic [NODE_W-1:0]  nl, nr, c_sel, c_new, new_l, new_r;
  logic [HOP_W-1:0]   nhop, hit_hop;
  logic               nrule, bit_cur, at_end, last_alloc;
  logic [LVL_W-1:0]   levels;
  logic [CNT_W-1:0]   need, cnt_dec;
  logic [ADDR_W-1:0]  addr_in;

  assign rd_root  = (rd_node_q == '0);
  assign nl       = rd_root ? root_l_q : l_rd_q;
  assign nr       = rd_root ? root_r_q : r_rd_q;
  assign nhop     = rd_root ? '0 : hop_rd_q;
  assign nrule    = rd_root ? 1'b1 : rule_rd_q;
  assign bit_cur  = addr_q[ADDR_W-1];
  assign c_sel    = bit_cur ? nr : nl;
  assign levels   = ver_q ? LVL_W'(MAX_LEVELS) : LVL_W'(V4_LEVELS);
  assign at_end   = (lvl_q == plen_q);
  assign need     = CNT_W'(plen_q) - CNT_W'(lvl_q);
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign hit_hop  = nrule ? nhop : res_q;
  assign c_new    = fs_orig_q ? (fs_idx_q + NODE_W'(1)) : fs_rd_q;
  assign last_alloc = ((LVL_W+1)'(lvl_q) + (LVL_W+1)'(1)) == (LVL_W+1)'(plen_q);
  // addr_high holds the most significant half of an IPv6 address
  assign addr_in  = ver_q ? {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                          : {s_axis_tdata[64+V4_W-1:64], {(ADDR_W-V4_W){1'b0}}};
  assign new_l    = (nl == cur_node_q) ? '0 : nl;
  assign new_r    = (nl == cur_node_q) ? nr : '0;

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_st_q, out_hop_q};
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    plen_d     = plen_q;
    hop_d      = hop_q;
    addr_d     = addr_q;
    lvl_d      = lvl_q;
    cur_node_d = cur_node_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    min_d      = min_q;
    root_l_d   = root_l_q;
    root_r_d   = root_r_q;
    fs_idx_d   = fs_idx_q;
    fs_orig_d  = fs_orig_q;
    new_d      = new_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_hop_d  = out_hop_q;
    out_st_d   = out_st_q;
    nd_re = 1'b0;  nd_ra = '0;
    nd_wa = '0;
    we_l = 1'b0; we_r = 1'b0; we_h = 1'b0; we_rule = 1'b0;
    wd_l = '0;  wd_r = '0;  wd_h = '0;  wd_rule = 1'b0;
    fs_re = 1'b0; fs_ra = '0;
    fs_we = 1'b0; fs_wa = '0; fs_wd = '0;
    ps_re = 1'b0; ps_ra = '0;
    ps_we = 1'b0; ps_wa = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          mode_d = s_axis_tuser;
          plen_d = s_axis_tdata[135:128];
          hop_d  = s_axis_tdata[143:136] & HOP_MASK;
          addr_d = addr_in;
          lvl_d  = '0;
          res_d  = '0;
          out_hop_d = '0;
          case (s_axis_tuser)
            MODE_LOOKUP: begin
              nd_re = 1'b1;
              state_d = S_WALK;
            end
            MODE_INSERT, MODE_DELETE: begin
              if (s_axis_tdata[135:128] == '0) begin
                out_valid_d = 1'b1;
                out_st_d = ST_ZERO;
              end else if (s_axis_tdata[135:128] > levels) begin
                out_valid_d = 1'b1;
                out_st_d = ST_LONG;
              end else begin
                nd_re = 1'b1;
                state_d = S_WALK;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              out_st_d = ST_OK;
            end
          endcase
        end
      end

      S_WALK: begin
        ps_we = 1'b1;
        ps_wa = lvl_q;
        cur_node_d = rd_node_q;
        if (mode_q == MODE_LOOKUP) begin
          res_d = hit_hop;
          if (lvl_q == levels || c_sel == '0) begin
            out_valid_d = 1'b1;
            out_hop_d = hit_hop;
            out_st_d = ST_OK;
            state_d = S_IDLE;
          end else begin
            nd_re = 1'b1;
            nd_ra = c_sel;
            lvl_d = lvl_q + LVL_W'(1);
            addr_d = addr_q << 1;
          end
        end else if (!at_end && c_sel != '0) begin
          nd_re = 1'b1;
          nd_ra = c_sel;
          lvl_d = lvl_q + LVL_W'(1);
          addr_d = addr_q << 1;
        end else if (mode_q == MODE_INSERT) begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          if (at_end && nrule) begin
            out_st_d = ST_EXISTS;
          end else if (need > cnt_q) begin
            out_st_d = ST_FULL;
          end else if (at_end) begin
            nd_wa = rd_node_q;
            we_h = 1'b1;  wd_h = hop_q;
            we_rule = 1'b1;  wd_rule = 1'b1;
            out_st_d = ST_OK;
          end else begin
            out_valid_d = 1'b0;
            state_d = S_POP;
          end
        end else begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          out_st_d = ST_OK;
          if (!at_end || !nrule) begin
            out_st_d = ST_NORULE;
          end else begin
            nd_wa = rd_node_q;
            we_h = 1'b1;
            we_rule = 1'b1;
            // empty leaf: start pruning toward the root
            if (nl == '0 && nr == '0) begin
              out_valid_d = 1'b0;
              state_d = S_PSRD;
            end
          end
        end
      end

      S_POP: begin
        fs_re = 1'b1;
        fs_ra = NODE_W'(cnt_dec);
        fs_idx_d = NODE_W'(cnt_dec);
        fs_orig_d = (cnt_dec < min_q);
        state_d = S_LINK;
      end

      S_LINK: begin
        new_d = c_new;
        if (cur_node_q == '0) begin
          if (bit_cur) root_r_d = c_new;
          else root_l_d = c_new;
        end else begin
          nd_wa = cur_node_q;
          we_l = !bit_cur;
          we_r = bit_cur;
          wd_l = c_new;
          wd_r = c_new;
        end
        cnt_d = cnt_dec;
        if (cnt_dec < min_q) min_d = cnt_dec;
        state_d = S_CLR;
      end

      S_CLR: begin
        nd_wa = new_q;
        we_l = 1'b1; we_r = 1'b1; we_h = 1'b1; we_rule = 1'b1;
        wd_h = last_alloc ? hop_q : '0;
        wd_rule = last_alloc;
        cur_node_d = new_q;
        lvl_d = lvl_q + LVL_W'(1);
        addr_d = addr_q << 1;
        if (last_alloc) begin
          out_valid_d = 1'b1;
          out_st_d = ST_OK;
          state_d = S_IDLE;
        end else begin
          state_d = S_POP;
        end
      end

      S_PSRD: begin
        ps_re = 1'b1;
        ps_ra = lvl_q - LVL_W'(1);
        state_d = S_NDRD;
      end

      S_NDRD: begin
        nd_re = 1'b1;
        nd_ra = ps_rd_q;
        state_d = S_UNLINK;
      end

      S_UNLINK: begin
        // drop the link from the parent, then free the child
        if (rd_root) begin
          root_l_d = new_l;
          root_r_d = new_r;
        end else begin
          nd_wa = rd_node_q;
          we_l = (nl == cur_node_q);
          we_r = (nl != cur_node_q);
        end
        if (cnt_q < CNT_W'(FREE_DEPTH)) begin
          fs_we = 1'b1;
          fs_wa = NODE_W'(cnt_q);
          fs_wd = cur_node_q;
          cnt_d = cnt_q + CNT_W'(1);
        end
        cur_node_d = rd_node_q;
        lvl_d = lvl_q - LVL_W'(1);
        if (lvl_q == LVL_W'(1) || new_l != '0 || new_r != '0 || nrule) begin
          out_valid_d = 1'b1;
          out_st_d = ST_OK;
          state_d = S_IDLE;
        end else begin
          state_d = S_PSRD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ver_q       <= 1'b0;
      cnt_q       <= CNT_W'(FREE_DEPTH);
      min_q       <= CNT_W'(FREE_DEPTH);
      root_l_q    <= '0;
      root_r_q    <= '0;
      rd_node_q   <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_LOOKUP;
      lvl_q       <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) ver_q <= cfg_wdata_i;
      cnt_q       <= cnt_d;
      min_q       <= min_d;
      root_l_q    <= root_l_d;
      root_r_q    <= root_r_d;
      if (nd_re) rd_node_q <= nd_ra;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      lvl_q       <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plen_q     <= plen_d;
    hop_q      <= hop_d;
    addr_q     <= addr_d;
    cur_node_q <= cur_node_d;
    res_q      <= res_d;
    fs_idx_q   <= fs_idx_d;
    fs_orig_q  <= fs_orig_d;
    new_q      <= new_d;
    out_hop_q  <= out_hop_d;
    out_st_q   <= out_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (nd_re) begin
      l_rd_q    <= left_mem[nd_ra];
      r_rd_q    <= right_mem[nd_ra];
      hop_rd_q  <= hop_mem[nd_ra];
      rule_rd_q <= rule_mem[nd_ra];
    end
    if (we_l)    left_mem[nd_wa]  <= wd_l;
    if (we_r)    right_mem[nd_wa] <= wd_r;
    if (we_h)    hop_mem[nd_wa]   <= wd_h;
    if (we_rule) rule_mem[nd_wa]  <= wd_rule;
  end

  always_ff @(posedge clk_i) begin
    if (fs_re) fs_rd_q <= free_mem[fs_ra];
    if (fs_we) free_mem[fs_wa] <= fs_wd;
  end

  always_ff @(posedge clk_i) begin
    if (ps_re) ps_rd_q <= path_mem[ps_ra];
    if (ps_we) path_mem[ps_wa] <= rd_node_q;
  end

endmodule

`default_nettype wire

### rtl/btlpm_checker.sv
// ----------------------------------------------------------------------------
// btlpm_checker
// Port-level checks for the binary trie prefix lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

module btlpm_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [15:0]  m_axis_tdata
);

  // one transaction in flight: no intake while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held after accepting a transaction");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:8] <= 3'd5 && m_axis_tdata[15:11] == 5'd0))
    else $error("status code out of range");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind binary_trie_prefix_lookup_unit btlpm_checker u_btlpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### test/binary_trie_prefix_lookup_unit_tb.sv
// ----------------------------------------------------------------------------
// binary_trie_prefix_lookup_unit_tb
// Self-checking bench for the binary trie longest-prefix match unit. A local
// trie model predicts each result; lookups, inserts and deletes run in IPv4
// and IPv6 mode with random stalls on both streams.
// ----------------------------------------------------------------------------
module binary_trie_prefix_lookup_unit_tb;
  import btlpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         TAIL_CYCLES = 40;

  typedef struct packed {
    logic [HOP_W-1:0] hop;
    status_e          status;
  } answer_t;

  typedef struct {
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic [PLEN_W-1:0] plen;
  } route_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;  // addr_high, addr_low, prefix_length, new_next_hop
  logic [1:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;       // next_hop, status, zero pad
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_wdata_i = 1'b0;

  binary_trie_prefix_lookup_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_wdata_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Trie model state
  logic [NODE_W-1:0] left_q  [NODE_COUNT];
  logic [NODE_W-1:0] right_q [NODE_COUNT];
  logic [HOP_W-1:0]  hop_q   [NODE_COUNT];
  logic              rule_q  [NODE_COUNT];
  logic [NODE_W-1:0] free_q  [NODE_COUNT];
  int                free_cnt;
  logic              ipv6_mode;

  answer_t pending_answers[$];
  route_t  live_routes[$];
  route_t  seed_routes[8];
  int      errors, sent_items, checked, quiet;
  int      status_seen[8];

  function automatic logic addr_bit(logic [63:0] hi, logic [63:0] lo, int i);
    if (!ipv6_mode) return lo[V4_LEVELS-1-i];
    if (i < 64) return hi[63-i];
    return lo[127-i];
  endfunction

  function automatic logic [NODE_W-1:0] child(logic [NODE_W-1:0] n, logic b);
    return b ? right_q[n] : left_q[n];
  endfunction

  task automatic trie_reset();
    for (int i = 0; i < NODE_COUNT; i++) begin
      left_q[i] = '0; right_q[i] = '0; hop_q[i] = '0; rule_q[i] = 1'b0;
      free_q[i] = NODE_W'(i + 1);
    end
    rule_q[0] = 1'b1;
    free_cnt = NODE_COUNT - 1;
    ipv6_mode = 1'b0;
  endtask

  task automatic trie_apply(input logic [1:0] mode, input logic [63:0] hi,
                            input logic [63:0] lo, input logic [PLEN_W-1:0] plen,
                            input logic [HOP_W-1:0] nhop, output answer_t ans);
    int levels, reached;
    logic [NODE_W-1:0] node, c, n, p;
    logic [NODE_W-1:0] path[PATH_DEPTH];
    levels = ipv6_mode ? MAX_LEVELS : V4_LEVELS;
    ans.hop = '0;
    ans.status = ST_OK;
    if (mode == MODE_LOOKUP) begin
      node = '0;
      ans.hop = hop_q[0];
      for (int i = 0; i < levels; i++) begin
        node = child(node, addr_bit(hi, lo, i));
        if (node == 0) break;
        if (rule_q[node]) ans.hop = hop_q[node];
      end
    end else if (mode == MODE_INSERT || mode == MODE_DELETE) begin
      if (plen == 0) ans.status = ST_ZERO;
      else if (plen > levels) ans.status = ST_LONG;
      else begin
        node = '0; path[0] = '0; reached = 0;
        while (reached < plen) begin
          c = child(node, addr_bit(hi, lo, reached));
          if (c == 0) break;
          node = c; reached++; path[reached] = node;
        end
        if (mode == MODE_INSERT) begin
          if (reached == plen && rule_q[node]) ans.status = ST_EXISTS;
          else if (plen - reached > free_cnt) ans.status = ST_FULL;
          else begin
            while (reached < plen) begin
              free_cnt--;
              c = free_q[free_cnt];
              left_q[c] = '0; right_q[c] = '0; hop_q[c] = '0; rule_q[c] = 1'b0;
              if (addr_bit(hi, lo, reached)) right_q[node] = c;
              else left_q[node] = c;
              node = c; reached++; path[reached] = node;
            end
            hop_q[node] = nhop & HOP_MASK;
            rule_q[node] = 1'b1;
          end
        end else if (reached != plen || !rule_q[node]) begin
          ans.status = ST_NORULE;
        end else begin
          hop_q[node] = '0;
          rule_q[node] = 1'b0;
          // prune empty branch nodes back toward the root
          for (int i = reached; i > 0; i--) begin
            n = path[i]; p = path[i-1];
            if (left_q[n] != 0 || right_q[n] != 0 || rule_q[n]) break;
            if (left_q[p] == n) left_q[p] = '0;
            else right_q[p] = '0;
            if (free_cnt < NODE_COUNT - 1) begin
              free_q[free_cnt] = n; free_cnt++;
            end
          end
        end
      end
    end
  endtask

  // Result checker and receiver stalls
  int rx_hold = 0;
  always @(posedge clk_i) begin
    answer_t exp_a;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
      end else begin
        exp_a = pending_answers.pop_front();
        checked++;
        if (m_axis_tdata[7:0] !== exp_a.hop) begin
          errors++;
          $display("%0t: next_hop expected %0d actual %0d", $time, exp_a.hop,
                   m_axis_tdata[7:0]);
        end
        if (m_axis_tdata[10:8] !== exp_a.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_a.status,
                   m_axis_tdata[10:8]);
        end
      end
    end
    if (quiet || !rst_ni) m_axis_tready <= 1'b1;
    else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= (rx_hold == 0);
    end else if ($urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(1, 18);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  // Send one transaction; tvalid stays high on return until the next call or idle
  task automatic send_item(input logic [1:0] mode, input logic [63:0] hi,
                           input logic [63:0] lo, input logic [PLEN_W-1:0] plen,
                           input logic [HOP_W-1:0] nhop, output status_e st);
    answer_t a;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    trie_apply(mode, hi, lo, plen, nhop, a);
    pending_answers.push_back(a);
    status_seen[a.status]++;
    st = a.status;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {nhop, plen, lo, hi};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_version(input logic v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ipv6_mode = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Insert a route and remember it for later deletes
  task automatic add_route(input route_t r, input logic [HOP_W-1:0] nhop);
    status_e st;
    send_item(MODE_INSERT, r.hi, r.lo, r.plen, nhop, st);
    if (st == ST_OK) live_routes.push_back(r);
  endtask

  task automatic remove_route(input int idx);
    status_e st;
    route_t r;
    r = live_routes[idx];
    send_item(MODE_DELETE, r.hi, r.lo, r.plen, '0, st);
    if (st == ST_OK) live_routes.delete(idx);
  endtask

  task automatic test_directed_v4();
    status_e st;
    route_t r;
    send_item(MODE_LOOKUP, '0, '0, '0, '0, st);
    send_item(MODE_INSERT, '0, 64'hC0A8_0000, 8'd0, 8'd7, st);
    send_item(MODE_DELETE, '0, 64'hC0A8_0000, 8'd0, 8'd7, st);
    send_item(MODE_INSERT, '0, 64'hC0A8_0000, 8'd33, 8'd7, st);
    send_item(MODE_INSERT, '1, '1, 8'hFF, 8'hFF, st);
    r = '{'0, 64'hC0A8_0000, 8'd16}; add_route(r, 8'd11);
    send_item(MODE_INSERT, '0, 64'hC0A8_0000, 8'd16, 8'd12, st);
    r = '{'1, 64'hFFFF_FFFF_FFFF_FFFF, 8'd32}; add_route(r, 8'hFF);
    r = '{'0, 64'h0, 8'd1}; add_route(r, 8'd1);
    send_item(MODE_LOOKUP, '0, 64'hC0A8_1234, '0, '0, st);
    send_item(MODE_LOOKUP, '0, 64'hFFFF_FFFF, '0, '0, st);
    send_item(MODE_LOOKUP, '0, 64'h0123_4567, '0, '0, st);
    send_item(MODE_DELETE, '0, 64'hC0A8_0000, 8'd15, '0, st);
    send_item(MODE_DELETE, '0, 64'hC0A9_0000, 8'd24, '0, st);
    send_item(MODE_UNUSED, '1, '1, 8'd16, 8'hAA, st);
    while (live_routes.size() != 0) remove_route(0);
    send_item(MODE_LOOKUP, '0, 64'hC0A8_1234, '0, '0, st);
  endtask

  // Fill the node pool with full-length IPv6 routes, then tear them down
  task automatic test_pool_full_v6();
    status_e st;
    route_t r;
    write_version(1'b1);
    st = ST_OK;
    while (st != ST_FULL) begin
      r = '{rand64(), rand64(), 8'd128};
      send_item(MODE_INSERT, r.hi, r.lo, r.plen, 8'($urandom), st);
      if (st == ST_OK) live_routes.push_back(r);
    end
    send_item(MODE_INSERT, r.hi, r.lo, 8'd129, 8'd3, st);
    send_item(MODE_LOOKUP, live_routes[0].hi, live_routes[0].lo, '0, '0, st);
    // hold off until the unit has returned everything
    drain();
    while (live_routes.size() != 0) remove_route($urandom_range(0, live_routes.size() - 1));
  endtask

  task automatic test_random(input int count, input logic v);
    status_e st;
    route_t r;
    int sel, d, levels;
    logic [127:0] a;
    write_version(v);
    levels = v ? MAX_LEVELS : V4_LEVELS;
    for (int k = 0; k < 8; k++) seed_routes[k] = '{rand64(), rand64(), 8'd0};
    for (int k = 0; k < count; k++) begin
      r = seed_routes[$urandom_range(0, 7)];
      d = $urandom_range(0, levels);
      if (v) begin
        a = {rand64(), rand64()} >> d;
        r.hi ^= a[127:64]; r.lo ^= a[63:0];
      end else begin
        r.hi = rand64();
        r.lo[31:0] ^= ($urandom >> d);
        r.lo[63:32] = $urandom;
      end
      r.plen = PLEN_W'($urandom_range(1, levels));
      sel = $urandom_range(0, 99);
      if (sel < 40) send_item(MODE_LOOKUP, r.hi, r.lo, 8'($urandom), 8'($urandom), st);
      else if (sel < 68) add_route(r, 8'($urandom));
      else if (sel < 90 && live_routes.size() != 0)
        remove_route($urandom_range(0, live_routes.size() - 1));
      else if (sel < 95)
        send_item(sel[0] ? MODE_INSERT : MODE_DELETE, r.hi, r.lo, 8'($urandom),
                  8'($urandom), st);
      else
        send_item(sel[0] ? MODE_UNUSED : MODE_DELETE, r.hi, r.lo, r.plen,
                  8'($urandom), st);
    end
  endtask

  initial begin
    trie_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_v4();
    test_pool_full_v6();
    test_random(250, 1'b0);
    test_random(200, 1'b1);
    test_random(120, 1'b0);
    quiet = 1;
    test_random(100, 1'b1);
    drain();
    if (pending_answers.size() != 0) errors++;
    $display("Sent %0d transactions, checked %0d results in IPv4 and IPv6 mode.",
             sent_items, checked);
    $display("Status counts ok/zero/exists/norule/full/long: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(12 * 4_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
